/* rtl/core/baro_sensor_compensation_core_assert.svh */
// Assertion macros shared by the compensation core.
// Both macros sample on the rising edge of clk and stay quiet while rst is high.
`ifndef BARO_SENSOR_COMPENSATION_CORE_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_CORE_ASSERT_SVH

// Same-cycle implication.
`define BARO_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("baro core: implication check failed");

// Next-cycle implication.
`define BARO_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("baro core: next-cycle check failed");

`endif

/* rtl/core/baro_pkg.sv */
`timescale 1ns / 1ps

package baro_pkg;

  localparam int SCALE_SHIFT_DEF = 19;

  localparam int RAW_W      = 24;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // Coefficient field widths in the sensor's packed layout.
  localparam int C_TEMP_W  = 12;
  localparam int C_OFS_W   = 20;
  localparam int C_CROSS_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_PAIR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LINEAR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CROSS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_TERMS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUBIC         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_VALID   = 3'd5;

  // Scale factors: c0/2 in millidegrees, and centipascals.
  localparam int TEMP_C0_HALF = 500;
  localparam int TEMP_MILLI   = 1000;
  localparam int PRESS_CENTI  = 100;

  // Pipeline depth from accept to result strobe.
  localparam int LATENCY          = 7;
  localparam int TRUNC_SAT_STAGES = 2;
  localparam int TEMP_STAGES      = 2;
  localparam int TEMP_DELAY       = LATENCY - TEMP_STAGES - TRUNC_SAT_STAGES;

  typedef struct packed {
    logic signed [C_TEMP_W-1:0]  c0;
    logic signed [C_TEMP_W-1:0]  c1;
    logic signed [C_OFS_W-1:0]   c00;
    logic signed [C_OFS_W-1:0]   c10;
    logic signed [C_CROSS_W-1:0] c01;
    logic signed [C_CROSS_W-1:0] c11;
    logic signed [C_CROSS_W-1:0] c20;
    logic signed [C_CROSS_W-1:0] c21;
    logic signed [C_CROSS_W-1:0] c30;
    logic                        calib_valid;
  } coef_t;

endpackage

/* rtl/core/baro_sensor_compensation_core.sv */
`timescale 1ns / 1ps
`include "baro_sensor_compensation_core_assert.svh"

// Barometric sensor compensation core.
//
// Input: a sample transaction (raw_temperature, raw_pressure) is taken at a rising
// edge where start is high and busy is low. The core is fully pipelined, so busy
// stays low and a new sample may be started in every cycle.
// Output: once a sample has passed through every pipeline stage, done pulses high
// for one cycle with status, temperature_millicelsius and pressure_centipascal. The
// receiver has no way to stall; results stream out in the order samples went in.
// Throughput is one sample per cycle; latency is set by the pressure path, which
// runs five arithmetic stages followed by two round-and-saturate stages.
// Configuration: the six coefficient registers are written through cfg_valid /
// cfg_ready with cfg_index and cfg_data; cfg_ready is always high. Writes must only
// happen while no sample is in flight.
// Reset: rst clears all coefficient registers (calibration not valid) and empties
// the pipeline; no done pulse comes out for samples that were in flight.
module baro_sensor_compensation_core import baro_pkg::*; #(
  parameter int SCALE_SHIFT = SCALE_SHIFT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [RAW_W-1:0] raw_temperature,
  input  logic signed [RAW_W-1:0] raw_pressure,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                    done,
  output logic                    status,
  output logic signed [OUT_W-1:0] temperature_millicelsius,
  output logic signed [OUT_W-1:0] pressure_centipascal
);

  coef_t coef;

  logic accept;
  logic [LATENCY-1:0] vld;
  logic [LATENCY-1:0] stat_pipe;
  logic signed [OUT_W-1:0] temp_val;
  logic signed [OUT_W-1:0] press_val;

  // The pipeline never stalls, so the core is always ready for a new sample.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  baro_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // Both datapaths register every cycle; the valid vector below marks which
  // stages hold a real sample.
  baro_temp_path #(
    .SCALE_SHIFT (SCALE_SHIFT)
  ) u_temp (
    .clk             (clk),
    .coef            (coef),
    .raw_temperature (raw_temperature),
    .temperature     (temp_val)
  );

  baro_press_path #(
    .SCALE_SHIFT (SCALE_SHIFT)
  ) u_press (
    .clk             (clk),
    .coef            (coef),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .pressure        (press_val)
  );

  // Valid bits travel alongside the data. The status bit is captured when the
  // sample is taken, since the calibration flag is what decides the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    stat_pipe <= {stat_pipe[LATENCY-2:0], !coef.calib_valid};
  end

  // Without a valid calibration both values read as zero.
  assign done                     = vld[LATENCY-1];
  assign status                   = stat_pipe[LATENCY-1];
  assign temperature_millicelsius = status ? '0 : temp_val;
  assign pressure_centipascal     = status ? '0 : press_val;

  // Every taken sample produces its result, and no result appears without a
  // sample behind it.
  `BARO_ASSERT_IMPLY(a_accept_gives_done, accept, ##LATENCY done)
  `BARO_ASSERT_IMPLY(a_done_has_accept, done, $past(accept, LATENCY))
  // The status follows the calibration flag seen when the sample was taken.
  `BARO_ASSERT_IMPLY(a_status_tracks_calib, done,
                     status == $past(!coef.calib_valid, LATENCY))
  // A write to the calibration flag register lands in the next cycle.
  `BARO_ASSERT_NEXT(a_calib_write, cfg_valid && cfg_ready && cfg_index == REG_CALIB_VALID,
                    coef.calib_valid == $past(cfg_data[0]))

endmodule

/* rtl/core/baro_cfg_regs.sv */
`timescale 1ns / 1ps

module baro_cfg_regs import baro_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output coef_t                 coef
);

  logic [23:0] temp_pair;
  logic [39:0] offset_linear;
  logic [31:0] temp_cross;
  logic [31:0] square_terms;
  logic [15:0] cubic;
  logic        calib_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_pair     <= '0;
      offset_linear <= '0;
      temp_cross    <= '0;
      square_terms  <= '0;
      cubic         <= '0;
      calib_valid   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEMP_PAIR:     temp_pair     <= cfg_data[23:0];
        REG_OFFSET_LINEAR: offset_linear <= cfg_data[39:0];
        REG_TEMP_CROSS:    temp_cross    <= cfg_data[31:0];
        REG_SQUARE_TERMS:  square_terms  <= cfg_data[31:0];
        REG_CUBIC:         cubic         <= cfg_data[15:0];
        REG_CALIB_VALID:   calib_valid   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    coef.c0          = $signed(temp_pair[23:12]);
    coef.c1          = $signed(temp_pair[11:0]);
    coef.c00         = $signed(offset_linear[39:20]);
    coef.c10         = $signed(offset_linear[19:0]);
    coef.c01         = $signed(temp_cross[31:16]);
    coef.c11         = $signed(temp_cross[15:0]);
    coef.c20         = $signed(square_terms[31:16]);
    coef.c21         = $signed(square_terms[15:0]);
    coef.c30         = $signed(cubic);
    coef.calib_valid = calib_valid;
  end

endmodule

/* rtl/core/baro_trunc_sat.sv */
`timescale 1ns / 1ps

// Divides a signed value by 2^SH, rounding toward zero, and clamps it to 32 bits.
module baro_trunc_sat import baro_pkg::*; #(
  parameter int IW = 48,
  parameter int SH = SCALE_SHIFT_DEF
) (
  input  logic                    clk,
  input  logic signed [IW-1:0]    din,
  output logic signed [OUT_W-1:0] dout
);

  localparam int QW = IW - SH;
  localparam int EW = QW + OUT_W;

  localparam logic signed [IW-1:0] BIAS = $signed({{(IW-SH){1'b0}}, {SH{1'b1}}});
  localparam logic signed [IW-1:0] NO_BIAS = '0;
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic signed [IW-1:0]    biased;
  logic signed [EW-1:0]    quot;
  logic                    fits;
  logic signed [OUT_W-1:0] dout_next;

  // A negative value gets 2^SH - 1 added so the shift below rounds toward zero.
  always_ff @(posedge clk) begin
    biased <= din + (din[IW-1] ? BIAS : NO_BIAS);
  end

  always_comb begin
    quot = EW'($signed(biased[IW-1:SH]));
    fits = (&quot[EW-1:OUT_W-1]) | ~(|quot[EW-1:OUT_W-1]);
    if (fits) begin
      dout_next = quot[OUT_W-1:0];
    end else if (quot[EW-1]) begin
      dout_next = OUT_MIN;
    end else begin
      dout_next = OUT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
  end

endmodule

/* rtl/core/baro_temp_path.sv */
`timescale 1ns / 1ps

module baro_temp_path import baro_pkg::*; #(
  parameter int SCALE_SHIFT = SCALE_SHIFT_DEF
) (
  input  logic                    clk,
  input  coef_t                   coef,
  input  logic signed [RAW_W-1:0] raw_temperature,
  output logic signed [OUT_W-1:0] temperature
);

  localparam int PROD_W = C_TEMP_W + RAW_W;
  localparam int OFS_W  = C_TEMP_W + 9 + SCALE_SHIFT;
  localparam int LIN_W  = PROD_W + 10;
  localparam int TW     = ((OFS_W > LIN_W) ? OFS_W : LIN_W) + 1;

  logic signed [PROD_W-1:0] ct;
  logic signed [TW-1:0]     tnum;
  logic signed [OUT_W-1:0]  rounded;
  logic signed [OUT_W-1:0]  temp_dly [TEMP_DELAY];

  always_ff @(posedge clk) begin
    ct   <= PROD_W'($signed(coef.c1)) * PROD_W'(raw_temperature);
    tnum <= ((TW'($signed(coef.c0)) * TW'(TEMP_C0_HALF)) <<< SCALE_SHIFT)
            + (TW'(ct) * TW'(TEMP_MILLI));
  end

  baro_trunc_sat #(
    .IW (TW),
    .SH (SCALE_SHIFT)
  ) u_round (
    .clk  (clk),
    .din  (tnum),
    .dout (rounded)
  );

  // Temperature finishes early; hold it until the pressure result is ready.
  always_ff @(posedge clk) begin
    temp_dly[0] <= rounded;
    for (int i = 1; i < TEMP_DELAY; i++) begin
      temp_dly[i] <= temp_dly[i-1];
    end
  end

  assign temperature = temp_dly[TEMP_DELAY-1];

endmodule

/* rtl/core/baro_press_path.sv */
`timescale 1ns / 1ps

// Pressure numerator in factored form over D = 2^S:
//   N = c00*D^3 + D^2*(c10*P + c01*T) + D*P*(c20*P + c11*T) + P^2*(c30*P + c21*T)
module baro_press_path import baro_pkg::*; #(
  parameter int SCALE_SHIFT = SCALE_SHIFT_DEF
) (
  input  logic                    clk,
  input  coef_t                   coef,
  input  logic signed [RAW_W-1:0] raw_temperature,
  input  logic signed [RAW_W-1:0] raw_pressure,
  output logic signed [OUT_W-1:0] pressure
);

  localparam int UW    = C_OFS_W + RAW_W + 1;
  localparam int VW    = C_CROSS_W + RAW_W + 1;
  localparam int SQ_W  = 2 * RAW_W;
  localparam int HI_W  = SQ_W - RAW_W;
  localparam int CU_A  = C_OFS_W + SCALE_SHIFT;
  localparam int CUW   = ((CU_A > UW) ? CU_A : UW) + 1;
  localparam int VP_W  = VW + RAW_W;
  localparam int WLO_W = VW + RAW_W + 1;
  localparam int WHI_W = VW + HI_W;
  localparam int WP_W  = WHI_W + RAW_W + 1;
  localparam int Y_A   = CUW + SCALE_SHIFT;
  localparam int YW    = ((Y_A > VP_W) ? Y_A : VP_W) + 1;
  localparam int N_A   = YW + SCALE_SHIFT;
  localparam int NW    = ((N_A > WP_W) ? N_A : WP_W) + 1;
  localparam int N100W = NW + 7;

  // Stage 1: first-order products and the square of the pressure.
  logic signed [UW-1:0]    u;
  logic signed [VW-1:0]    v;
  logic signed [VW-1:0]    w;
  logic signed [SQ_W-1:0]  p2;
  logic signed [RAW_W-1:0] p1;

  always_ff @(posedge clk) begin
    u  <= UW'($signed(coef.c10)) * UW'(raw_pressure)
          + UW'($signed(coef.c01)) * UW'(raw_temperature);
    v  <= VW'($signed(coef.c20)) * VW'(raw_pressure)
          + VW'($signed(coef.c11)) * VW'(raw_temperature);
    w  <= VW'($signed(coef.c30)) * VW'(raw_pressure)
          + VW'($signed(coef.c21)) * VW'(raw_temperature);
    p2 <= SQ_W'(raw_pressure) * SQ_W'(raw_pressure);
    p1 <= raw_pressure;
  end

  // Stage 2: w * P^2 is split on the square's halves to keep each multiplier narrow.
  logic signed [CUW-1:0]   cu;
  logic signed [VP_W-1:0]  vp;
  logic signed [WLO_W-1:0] wlo;
  logic signed [WHI_W-1:0] whi;

  always_ff @(posedge clk) begin
    cu  <= (CUW'($signed(coef.c00)) <<< SCALE_SHIFT) + CUW'(u);
    vp  <= VP_W'(v) * VP_W'(p1);
    wlo <= WLO_W'(w) * WLO_W'($signed({1'b0, p2[RAW_W-1:0]}));
    whi <= WHI_W'(w) * WHI_W'($signed(p2[SQ_W-1:RAW_W]));
  end

  // Stage 3: recombine the partial products, fold in the next Horner step.
  logic signed [YW-1:0]   y;
  logic signed [WP_W-1:0] wp2;

  always_ff @(posedge clk) begin
    y   <= (YW'(cu) <<< SCALE_SHIFT) + YW'(vp);
    wp2 <= (WP_W'(whi) <<< RAW_W) + WP_W'(wlo);
  end

  // Stages 4 and 5: full numerator, then the centipascal scale.
  logic signed [NW-1:0]    n;
  logic signed [N100W-1:0] n100;

  always_ff @(posedge clk) begin
    n    <= (NW'(y) <<< SCALE_SHIFT) + NW'(wp2);
    n100 <= N100W'(n) * N100W'(PRESS_CENTI);
  end

  baro_trunc_sat #(
    .IW (N100W),
    .SH (3 * SCALE_SHIFT)
  ) u_round (
    .clk  (clk),
    .din  (n100),
    .dout (pressure)
  );

endmodule
